// ===== hw/rtl/utf8_to_utf16_transcoder_macros.svh =====
// Assertion macros shared by the UTF-8 to UTF-16 transcoder RTL.
`ifndef UTF8_TO_UTF16_TRANSCODER_MACROS_SVH
`define UTF8_TO_UTF16_TRANSCODER_MACROS_SVH

`ifndef NO_ASSERTIONS

// cond must never hold outside reset
`define U2U_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

// when ante holds, cons must hold in the following cycle
`define U2U_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("expected follow-up condition missing");

`else

`define U2U_ASSERT_NEVER(label, clk, rst, cond)
`define U2U_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== hw/rtl/u8u16_pkg.sv =====
// Shared types and constants of the UTF-8 to UTF-16 transcoder.
package u8u16_pkg;

  localparam int unsigned CFG_W = 9;
  localparam logic [CFG_W-1:0] MAX_UNITS_RESET = 9'd128;

  // One queue entry: up to two code units, optionally followed by the terminator.
  typedef struct packed {
    logic [1:0]  n_units;
    logic        term;
    logic [15:0] unit0;
    logic [15:0] unit1;
  } entry_t;

endpackage

// ===== hw/rtl/u8u16_front.sv =====
// Front end: accepts bytes, tracks the open sequence and unit budget, builds queue entries.
`include "utf8_to_utf16_transcoder_macros.svh"

module u8u16_front #(
  parameter int unsigned UNIT_COUNT_MAX = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_byte,
  input  logic                          end_of_text,
  input  logic [u8u16_pkg::CFG_W-1:0]   max_units,
  input  logic                          q_full,
  output logic                          q_push,
  output u8u16_pkg::entry_t             q_data
);
  import u8u16_pkg::*;

  localparam int unsigned CfgMax = (1 << CFG_W) - 1;
  localparam int unsigned LimMax = (UNIT_COUNT_MAX < CfgMax) ? UNIT_COUNT_MAX : CfgMax;
  localparam int unsigned UnitW  = $clog2(LimMax + 1);

  localparam logic [5:0]  HiSurr   = 6'b110110;
  localparam logic [5:0]  LoSurr   = 6'b110111;
  localparam logic [20:0] PlaneOne = 21'h010000;
  localparam logic [20:0] CpMax    = 21'h10FFFF;

  logic [1:0]       need, need_next;
  logic [1:0]       seen, seen_next;
  logic [14:0]      acc, acc_next;
  logic             seq_ok, seq_ok_next;
  logic [7:0]       pend_byte, pend_byte_next;
  logic [UnitW-1:0] units, units_next;

  logic             accept;
  logic             eot;
  logic [7:0]       c;
  logic [UnitW-1:0] lim;
  logic             room1, room2;
  logic [1:0]       lead_len;
  logic [4:0]       lead_bits;
  logic             is_cont;
  logic [20:0]      cp;
  logic [20:0]      v;
  logic [15:0]      tail_unit;
  logic [1:0]       n_out;
  logic [15:0]      u0, u1;

  assign c        = in_byte;
  assign eot      = end_of_text;
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  assign lim   = ({{(32-CFG_W){1'b0}}, max_units} < LimMax) ? max_units[UnitW-1:0]
                                                             : LimMax[UnitW-1:0];
  assign room1 = units < lim;
  assign room2 = ({1'b0, units} + (UnitW+1)'(1)) < {1'b0, lim};

  assign is_cont   = c[7:6] == 2'b10;
  assign cp        = {acc, c[5:0]};
  assign v         = cp - PlaneOne;
  assign tail_unit = {5'b00000, pend_byte[4:0], c[5:0]};

  always_comb begin
    lead_len  = 2'd0;
    lead_bits = 5'd0;
    priority if (c[7:5] == 3'b110) begin
      lead_len  = 2'd1;
      lead_bits = c[4:0];
    end else if (c[7:4] == 4'b1110) begin
      lead_len  = 2'd2;
      lead_bits = {1'b0, c[3:0]};
    end else if (c[7:3] == 5'b11110) begin
      lead_len  = 2'd3;
      lead_bits = {2'b00, c[2:0]};
    end else begin
      lead_len  = 2'd0;
      lead_bits = 5'd0;
    end
  end

  always_comb begin
    need_next      = need;
    seen_next      = seen;
    acc_next       = acc;
    seq_ok_next    = seq_ok;
    pend_byte_next = pend_byte;
    units_next     = units;
    n_out          = 2'd0;
    u0             = '0;
    u1             = '0;

    if (accept) begin
      priority if (need == 2'd0) begin
        if (room1) begin
          if (!c[7]) begin
            n_out      = 2'd1;
            u0         = {8'h00, c};
            units_next = units + UnitW'(1);
          end else if (lead_len != 2'd0 && !eot) begin
            need_next   = lead_len;
            seen_next   = 2'd0;
            acc_next    = {10'd0, lead_bits};
            seq_ok_next = 1'b1;
          end
        end
      end else if (({1'b0, seen} + 3'd1) >= {1'b0, need}) begin
        // last continuation byte closes the character
        need_next   = 2'd0;
        seen_next   = 2'd0;
        acc_next    = '0;
        seq_ok_next = 1'b1;
        if (seq_ok && is_cont) begin
          if (cp[20:16] == 5'd0) begin
            if (cp[15:11] != 5'b11011 && room1) begin
              n_out      = 2'd1;
              u0         = cp[15:0];
              units_next = units + UnitW'(1);
            end
          end else if (cp <= CpMax && room2) begin
            n_out      = 2'd2;
            u0         = {HiSurr, v[19:10]};
            u1         = {LoSurr, v[9:0]};
            units_next = units + UnitW'(2);
          end
        end
      end else if (eot) begin
        // text ends mid-sequence: drop the lead, re-decode buffered byte and this one
        need_next   = 2'd0;
        seen_next   = 2'd0;
        acc_next    = '0;
        seq_ok_next = 1'b1;
        if (room1) begin
          if (seen == 2'd0) begin
            if (!c[7]) begin
              n_out = 2'd1;
              u0    = {8'h00, c};
            end
          end else begin
            priority if (!pend_byte[7]) begin
              n_out = 2'd1;
              u0    = {8'h00, pend_byte};
              if (room2 && !c[7]) begin
                n_out = 2'd2;
                u1    = {8'h00, c};
              end
            end else if (pend_byte[7:5] == 3'b110) begin
              if (is_cont) begin
                n_out = 2'd1;
                u0    = tail_unit;
              end
            end else begin
              if (!c[7]) begin
                n_out = 2'd1;
                u0    = {8'h00, c};
              end
            end
          end
        end
      end else begin
        // only the first buffered byte is ever re-decoded
        if (seen == 2'd0) begin
          pend_byte_next = c;
        end
        if (seq_ok && is_cont) begin
          acc_next = {acc[8:0], c[5:0]};
        end else begin
          seq_ok_next = 1'b0;
        end
        seen_next = seen + 2'd1;
      end

      if (eot) begin
        need_next   = 2'd0;
        seen_next   = 2'd0;
        acc_next    = '0;
        seq_ok_next = 1'b1;
        units_next  = '0;
      end
    end
  end

  assign q_push = accept && (n_out != 2'd0 || eot);
  always_comb begin
    q_data.n_units = n_out;
    q_data.term    = eot;
    q_data.unit0   = u0;
    q_data.unit1   = u1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      need   <= 2'd0;
      seen   <= 2'd0;
      acc    <= '0;
      seq_ok <= 1'b1;
      units  <= '0;
    end else begin
      need   <= need_next;
      seen   <= seen_next;
      acc    <= acc_next;
      seq_ok <= seq_ok_next;
      units  <= units_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_byte <= pend_byte_next;
  end

  `U2U_ASSERT_NEXT(a_text_end_clears, clk, rst, accept && end_of_text, units == '0 && need == 2'd0)

endmodule

// ===== hw/rtl/u8u16_fifo.sv =====
// Short entry queue between the front end and the output sequencer.
`include "utf8_to_utf16_transcoder_macros.svh"

module u8u16_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  u8u16_pkg::entry_t wr_data,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output u8u16_pkg::entry_t head
);
  import u8u16_pkg::*;

  localparam int unsigned Depth = 4;
  localparam int unsigned AW    = $clog2(Depth);

  entry_t          slots [Depth];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [AW:0]     count, count_next;

  assign full       = count == (AW+1)'(Depth);
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];

  always_comb begin
    unique case ({push, pop})
      2'b10:   count_next = count + (AW+1)'(1);
      2'b01:   count_next = count - (AW+1)'(1);
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  `U2U_ASSERT_NEVER(a_no_overflow, clk, rst, push && full)
  `U2U_ASSERT_NEVER(a_no_underflow, clk, rst, pop && !head_valid)

endmodule

// ===== hw/rtl/u8u16_back.sv =====
// Back end: walks each queue entry and drives the registered output request.
`include "utf8_to_utf16_transcoder_macros.svh"

module u8u16_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  u8u16_pkg::entry_t head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [15:0]       code_unit,
  output logic              is_final
);
  import u8u16_pkg::*;

  logic [1:0]  piece;
  logic [1:0]  pieces;
  logic        last;
  logic        load;
  logic [15:0] unit_sel;
  logic        fin_sel;

  assign pieces = head.n_units + {1'b0, head.term};
  assign last   = (piece + 2'd1) == pieces;
  assign load   = head_valid && (!out_valid || !out_stall);
  assign pop    = load && last;

  always_comb begin
    if (piece < head.n_units) begin
      unit_sel = piece[0] ? head.unit1 : head.unit0;
      fin_sel  = 1'b0;
    end else begin
      unit_sel = 16'h0000;
      fin_sel  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      piece     <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        piece     <= last ? 2'd0 : piece + 2'd1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code_unit <= unit_sel;
      is_final  <= fin_sel;
    end
  end

  `U2U_ASSERT_NEVER(a_piece_in_range, clk, rst, head_valid && piece >= pieces)

endmodule

// ===== hw/rtl/utf8_to_utf16_transcoder.sv =====
// Top level of the UTF-8 to UTF-16 transcoder: config register, front end, queue, back end.
// A unit caused by an accepted byte is written into the queue, then loaded into the output register.
// Throughput: one byte per cycle while the queue is not full; the output register sends one
// unit per cycle unless stalled; a 4-entry queue absorbs surrogate pairs and terminators.
// Reset (synchronous): clears sequence state, unit count, queue and output valid; max_units -> 128.
module utf8_to_utf16_transcoder #(
  parameter int unsigned UNIT_COUNT_MAX = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_byte,
  input  logic                        end_of_text,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [15:0]                 code_unit,
  output logic                        is_final,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [u8u16_pkg::CFG_W-1:0] max_units
);
  import u8u16_pkg::*;

  logic [CFG_W-1:0] max_units_cfg;
  logic             q_full;
  logic             q_push;
  entry_t           q_data;
  logic             q_pop;
  logic             q_head_valid;
  entry_t           q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_units_cfg <= MAX_UNITS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_units_cfg <= max_units;
    end
  end

  u8u16_front #(
    .UNIT_COUNT_MAX(UNIT_COUNT_MAX)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .end_of_text(end_of_text),
    .max_units  (max_units_cfg),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_data)
  );

  u8u16_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wr_data   (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_head_valid),
    .head      (q_head)
  );

  u8u16_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(q_head_valid),
    .head      (q_head),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .code_unit (code_unit),
    .is_final  (is_final)
  );

endmodule
